FILE: sv/fms_pkg.sv
// Shared types and constants for the flight mode supervisor.
// Used by the decision core, the top level and the testbench.
package fms_pkg;

  localparam int unsigned CFG_ADDR_W = 3;

  typedef enum logic [3:0] {
    CMD_TICK      = 4'd0,
    CMD_LOW_SP    = 4'd1,
    CMD_STREAM_STOP = 4'd2,
    CMD_TAKEOFF   = 4'd3,
    CMD_LAND      = 4'd4,
    CMD_GOTO      = 4'd5,
    CMD_START_TRAJ = 4'd6,
    CMD_FIN_QUERY = 4'd7,
    CMD_ESTOP     = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_EMERG    = 3'd1,
    MODE_LO_LEVEL = 3'd2,
    MODE_LEVEL    = 3'd3,
    MODE_AWAIT    = 3'd4,
    MODE_HI_LEVEL = 3'd5,
    MODE_LANDING  = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PERM    = 2'd1,
    ST_REFUSED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SRC_NULL  = 2'd0,
    SRC_LOW   = 2'd1,
    SRC_LEVEL = 2'd2,
    SRC_TRAJ  = 2'd3
  } source_t;

  typedef enum logic {
    REG_LEVELING  = 1'b0,
    REG_EMERGENCY = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] now_ms;
    logic [31:0] setpoint_time;
    logic [31:0] await_ms;
    logic        planner_accepted;
    logic        plan_finished;
    logic        eval_valid;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] mode_now;
    logic [1:0] output_source;
    logic       finished;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] last_low_time;
    logic [31:0] await_limit;
  } state_t;

  typedef struct packed {
    logic [31:0] leveling_timeout;
    logic [31:0] emergency_timeout;
  } cfg_t;

endpackage

FILE: sv/fms_if.sv
// Valid/ready channel interfaces for event words and result words.
// Does not depend on fms_pkg; the field widths are given here.
interface fms_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [31:0] now_ms;
  logic [31:0] setpoint_time;
  logic [31:0] await_ms;
  logic        planner_accepted;
  logic        plan_finished;
  logic        eval_valid;

  modport source (output valid, cmd, now_ms, setpoint_time, await_ms,
                  planner_accepted, plan_finished, eval_valid, input ready);
  modport sink (input valid, cmd, now_ms, setpoint_time, await_ms,
                planner_accepted, plan_finished, eval_valid, output ready);
endinterface

interface fms_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [2:0] mode_now;
  logic [1:0] output_source;
  logic       finished;

  modport source (output valid, status, mode_now, output_source, finished,
                  input ready);
  modport sink (input valid, status, mode_now, output_source, finished,
                output ready);
endinterface

FILE: sv/fms_core.sv
// Mode decision logic: next state and result word for one event word.
// Purely combinational; depends on fms_pkg.
module fms_core (
  input  fms_pkg::in_word_t  in_word,
  input  fms_pkg::state_t    state,
  input  fms_pkg::cfg_t      cfg,
  output fms_pkg::state_t    state_nxt,
  output fms_pkg::out_word_t result
);

  logic [31:0] elapsed;
  logic [31:0] limit;
  logic        expired;
  logic        mode_hi;

  assign elapsed = in_word.now_ms - state.last_low_time;
  assign mode_hi = (state.mode == fms_pkg::MODE_HI_LEVEL) ||
                   (state.mode == fms_pkg::MODE_IDLE) ||
                   (state.mode == fms_pkg::MODE_AWAIT);

  always_comb begin
    case (state.mode)
      fms_pkg::MODE_LO_LEVEL: limit = cfg.leveling_timeout;
      fms_pkg::MODE_LEVEL:    limit = cfg.emergency_timeout;
      default:                limit = state.await_limit;
    endcase
  end

  assign expired = elapsed > limit;

  always_comb begin
    logic [2:0] m;
    m = state.mode;
    state_nxt = state;
    result.status = fms_pkg::ST_OK;
    result.output_source = fms_pkg::SRC_NULL;
    result.finished = 1'b0;
    case (in_word.cmd)
      fms_pkg::CMD_TICK: begin
        case (m)
          fms_pkg::MODE_LO_LEVEL: if (expired) m = fms_pkg::MODE_LEVEL;
          fms_pkg::MODE_LEVEL:    if (expired) m = fms_pkg::MODE_EMERG;
          fms_pkg::MODE_AWAIT:    if (expired) m = fms_pkg::MODE_EMERG;
          fms_pkg::MODE_LANDING:  if (in_word.plan_finished) m = fms_pkg::MODE_IDLE;
          default: ;
        endcase
        if ((m == fms_pkg::MODE_HI_LEVEL || m == fms_pkg::MODE_LANDING) &&
            !in_word.eval_valid) begin
          m = fms_pkg::MODE_EMERG;
        end
        case (m)
          fms_pkg::MODE_LO_LEVEL, fms_pkg::MODE_AWAIT:
            result.output_source = fms_pkg::SRC_LOW;
          fms_pkg::MODE_LEVEL:
            result.output_source = fms_pkg::SRC_LEVEL;
          fms_pkg::MODE_HI_LEVEL, fms_pkg::MODE_LANDING:
            result.output_source = fms_pkg::SRC_TRAJ;
          default:
            result.output_source = fms_pkg::SRC_NULL;
        endcase
      end
      fms_pkg::CMD_LOW_SP: begin
        if (m inside {fms_pkg::MODE_IDLE, fms_pkg::MODE_LO_LEVEL, fms_pkg::MODE_LEVEL,
                      fms_pkg::MODE_HI_LEVEL}) begin
          state_nxt.last_low_time = in_word.setpoint_time;
          m = fms_pkg::MODE_LO_LEVEL;
        end else begin
          result.status = fms_pkg::ST_PERM;
        end
      end
      fms_pkg::CMD_STREAM_STOP: begin
        if (m == fms_pkg::MODE_LO_LEVEL) begin
          state_nxt.await_limit = in_word.await_ms;
          m = fms_pkg::MODE_AWAIT;
        end else begin
          result.status = fms_pkg::ST_PERM;
        end
      end
      fms_pkg::CMD_TAKEOFF: begin
        if (m != fms_pkg::MODE_IDLE) begin
          result.status = fms_pkg::ST_PERM;
        end else if (!in_word.planner_accepted) begin
          result.status = fms_pkg::ST_REFUSED;
        end else begin
          m = fms_pkg::MODE_HI_LEVEL;
        end
      end
      fms_pkg::CMD_LAND: begin
        if (!(m == fms_pkg::MODE_HI_LEVEL || m == fms_pkg::MODE_AWAIT)) begin
          result.status = fms_pkg::ST_PERM;
        end else if (!in_word.planner_accepted) begin
          result.status = fms_pkg::ST_REFUSED;
        end else begin
          m = fms_pkg::MODE_LANDING;
        end
      end
      fms_pkg::CMD_GOTO, fms_pkg::CMD_START_TRAJ: begin
        if (!mode_hi) begin
          result.status = fms_pkg::ST_PERM;
        end else if (!in_word.planner_accepted) begin
          result.status = fms_pkg::ST_REFUSED;
        end else begin
          m = fms_pkg::MODE_HI_LEVEL;
        end
      end
      fms_pkg::CMD_FIN_QUERY: begin
        if (m == fms_pkg::MODE_HI_LEVEL || m == fms_pkg::MODE_LANDING) begin
          result.finished = in_word.plan_finished;
        end else begin
          result.status = fms_pkg::ST_PERM;
        end
      end
      fms_pkg::CMD_ESTOP: m = fms_pkg::MODE_EMERG;
      default: result.status = fms_pkg::ST_PERM;
    endcase
    state_nxt.mode = m;
    result.mode_now = m;
  end

endmodule

FILE: sv/flight_mode_supervisor.sv
// Flight mode supervisor top level: input word register, decision core,
// result word register, mode/timer state and the APB register file.
// Depends on fms_pkg, fms_in_if, fms_out_if and fms_core.
//
// Usage:
//   in_ch carries one event word per valid/ready handshake; out_ch returns
//   exactly one result word per event, in order. An event word is latched
//   at its handshake and decided against the current mode and timers while
//   it sits in the input register; its result word is registered in the
//   result register once that register is empty or being read.
//   One word per cycle is sustained while out_ch.ready stays high. The only
//   loop is the mode/timer state, updated when the result register loads.
//   When the receiver stalls, the result register holds its word and the
//   input register fills; in_ch.ready drops only while both are full.
//   The registers leveling_timeout (0x0) and emergency_timeout (0x4) are
//   written through the APB port (pready tied high, no wait states) and
//   read back on prdata.
//   Synchronous active-low reset empties both word registers, sets the mode
//   to idle and clears the timers and both timeout registers.
module flight_mode_supervisor (
  input  logic                             clk,
  input  logic                             rst_n,
  fms_in_if.sink                           in_ch,
  fms_out_if.source                        out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fms_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic               in_v_r;
  fms_pkg::in_word_t  in_r;
  logic               out_v_r;
  fms_pkg::out_word_t out_r;
  fms_pkg::state_t    state_r;
  fms_pkg::state_t    state_nxt;
  fms_pkg::cfg_t      cfg_r;
  fms_pkg::out_word_t result;
  logic               advance;
  logic               fire;
  logic               cfg_wr;

  assign advance = !out_v_r || out_ch.ready;
  assign fire = in_v_r && advance;
  assign in_ch.ready = !in_v_r || advance;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == fms_pkg::REG_EMERGENCY) ? cfg_r.emergency_timeout
                                                         : cfg_r.leveling_timeout;

  fms_core u_core (
    .in_word   (in_r),
    .state     (state_r),
    .cfg       (cfg_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '{mode: fms_pkg::MODE_IDLE, last_low_time: '0, await_limit: '0};
      cfg_r   <= '0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
      if (fire) begin
        state_r <= state_nxt;
      end
      if (cfg_wr) begin
        if (paddr[2] == fms_pkg::REG_EMERGENCY) begin
          cfg_r.emergency_timeout <= pwdata;
        end else begin
          cfg_r.leveling_timeout <= pwdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r <= '{cmd: in_ch.cmd, now_ms: in_ch.now_ms, setpoint_time: in_ch.setpoint_time,
                await_ms: in_ch.await_ms, planner_accepted: in_ch.planner_accepted,
                plan_finished: in_ch.plan_finished, eval_valid: in_ch.eval_valid};
    end
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.mode_now      = out_r.mode_now;
  assign out_ch.output_source = out_r.output_source;
  assign out_ch.finished      = out_r.finished;

`ifndef SYNTHESIS
  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_v_r)
    else $error("decided word not registered");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(out_r))
    else $error("stalled result word changed");
  a_fin_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.finished |->
      out_r.mode_now == fms_pkg::MODE_HI_LEVEL || out_r.mode_now == fms_pkg::MODE_LANDING)
    else $error("finished flag outside trajectory modes");
  a_traj_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.output_source == fms_pkg::SRC_TRAJ |->
      out_r.mode_now == fms_pkg::MODE_HI_LEVEL || out_r.mode_now == fms_pkg::MODE_LANDING)
    else $error("trajectory source outside trajectory modes");
  a_mode_sync: assert property (@(posedge clk) disable iff (!rst_n)
    $past(fire) |-> out_r.mode_now == state_r.mode)
    else $error("result mode differs from held mode");
`endif

endmodule

FILE: tb/flight_mode_supervisor_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for flight_mode_supervisor: the opening rows of a table,
// random event words under random idling checked against a mode predictor, the closing rows.
// Depends on fms_pkg, fms_in_if, fms_out_if and the flight_mode_supervisor RTL.
module flight_mode_supervisor_tb;

  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned STALL_CYCLES = 80;
  localparam int unsigned PHASE_WORDS = 190;

  typedef struct packed {
    fms_pkg::status_t status;
    fms_pkg::mode_t   mode;
    fms_pkg::source_t src;
    logic             fin;
  } verdict_t;

  typedef struct packed {
    fms_pkg::mode_t mode;
    logic [31:0]    last_low;
    logic [31:0]    await_limit;
  } sup_state_t;

  typedef struct packed {
    fms_pkg::in_word_t ev;
    bit                pinned;
    verdict_t          want;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [fms_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  fms_in_if in_ch();
  fms_out_if out_ch();

  flight_mode_supervisor dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sup_state_t  flight_state = '{fms_pkg::MODE_IDLE, 32'd0, 32'd0};
  logic [31:0] lev_limit = 32'd0;
  logic [31:0] emg_limit = 32'd0;
  logic [31:0] lev_plan [6] = '{32'd0, 32'hFFFF_FFFF, 32'd20, 32'd3, 32'hFFFF_FFFF, 32'd0};
  logic [31:0] emg_plan [6] = '{32'd0, 32'hFFFF_FFFF, 32'd10, 32'hFFFF_FFFF, 32'd0, 32'd0};
  verdict_t    due_verdicts[$];
  script_row_t script[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  function automatic verdict_t supervise(input sup_state_t s, input fms_pkg::in_word_t ev,
                                         output sup_state_t ns);
    verdict_t v;
    logic [31:0] elapsed;
    v = '{fms_pkg::ST_OK, s.mode, fms_pkg::SRC_NULL, 1'b0};
    ns = s;
    elapsed = ev.now_ms - s.last_low;
    case (ev.cmd)
      fms_pkg::CMD_TICK: begin
        case (s.mode)
          fms_pkg::MODE_LO_LEVEL: if (elapsed > lev_limit) ns.mode = fms_pkg::MODE_LEVEL;
          fms_pkg::MODE_LEVEL:    if (elapsed > emg_limit) ns.mode = fms_pkg::MODE_EMERG;
          fms_pkg::MODE_AWAIT:
            if (elapsed > s.await_limit) ns.mode = fms_pkg::MODE_EMERG;
          fms_pkg::MODE_LANDING:  if (ev.plan_finished) ns.mode = fms_pkg::MODE_IDLE;
          default: ;
        endcase
        if ((ns.mode == fms_pkg::MODE_HI_LEVEL || ns.mode == fms_pkg::MODE_LANDING) &&
            !ev.eval_valid)
          ns.mode = fms_pkg::MODE_EMERG;
        case (ns.mode)
          fms_pkg::MODE_LO_LEVEL, fms_pkg::MODE_AWAIT:  v.src = fms_pkg::SRC_LOW;
          fms_pkg::MODE_LEVEL:                          v.src = fms_pkg::SRC_LEVEL;
          fms_pkg::MODE_HI_LEVEL, fms_pkg::MODE_LANDING: v.src = fms_pkg::SRC_TRAJ;
          default:                                      v.src = fms_pkg::SRC_NULL;
        endcase
      end
      fms_pkg::CMD_LOW_SP: begin
        if (s.mode == fms_pkg::MODE_IDLE || s.mode == fms_pkg::MODE_LO_LEVEL ||
            s.mode == fms_pkg::MODE_LEVEL || s.mode == fms_pkg::MODE_HI_LEVEL) begin
          ns.last_low = ev.setpoint_time;
          ns.mode = fms_pkg::MODE_LO_LEVEL;
        end else v.status = fms_pkg::ST_PERM;
      end
      fms_pkg::CMD_STREAM_STOP: begin
        if (s.mode == fms_pkg::MODE_LO_LEVEL) begin
          ns.await_limit = ev.await_ms;
          ns.mode = fms_pkg::MODE_AWAIT;
        end else v.status = fms_pkg::ST_PERM;
      end
      fms_pkg::CMD_TAKEOFF: begin
        if (s.mode != fms_pkg::MODE_IDLE) v.status = fms_pkg::ST_PERM;
        else if (!ev.planner_accepted) v.status = fms_pkg::ST_REFUSED;
        else ns.mode = fms_pkg::MODE_HI_LEVEL;
      end
      fms_pkg::CMD_LAND: begin
        if (s.mode != fms_pkg::MODE_HI_LEVEL && s.mode != fms_pkg::MODE_AWAIT)
          v.status = fms_pkg::ST_PERM;
        else if (!ev.planner_accepted) v.status = fms_pkg::ST_REFUSED;
        else ns.mode = fms_pkg::MODE_LANDING;
      end
      fms_pkg::CMD_GOTO, fms_pkg::CMD_START_TRAJ: begin
        if (s.mode != fms_pkg::MODE_IDLE && s.mode != fms_pkg::MODE_HI_LEVEL &&
            s.mode != fms_pkg::MODE_AWAIT)
          v.status = fms_pkg::ST_PERM;
        else if (!ev.planner_accepted) v.status = fms_pkg::ST_REFUSED;
        else ns.mode = fms_pkg::MODE_HI_LEVEL;
      end
      fms_pkg::CMD_FIN_QUERY: begin
        if (s.mode == fms_pkg::MODE_HI_LEVEL || s.mode == fms_pkg::MODE_LANDING)
          v.fin = ev.plan_finished;
        else v.status = fms_pkg::ST_PERM;
      end
      fms_pkg::CMD_ESTOP: ns.mode = fms_pkg::MODE_EMERG;
      default: v.status = fms_pkg::ST_PERM;
    endcase
    v.mode = ns.mode;
    return v;
  endfunction

  // Mostly commands that the current mode permits, with timestamps near the limits.
  function automatic fms_pkg::in_word_t draw_event(bit allow_emerg);
    fms_pkg::in_word_t ev;
    sup_state_t ns;
    int unsigned r, k, tries;
    tries = 0;
    do begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 4);
      if (r < 25) ev.cmd = fms_pkg::CMD_TICK;
      else if (r < 80) begin
        case (flight_state.mode)
          fms_pkg::MODE_IDLE:
            ev.cmd = k == 0 ? fms_pkg::CMD_LOW_SP : k == 1 ? fms_pkg::CMD_TAKEOFF :
                     k == 2 ? fms_pkg::CMD_GOTO : fms_pkg::CMD_START_TRAJ;
          fms_pkg::MODE_LO_LEVEL:
            ev.cmd = k[0] ? fms_pkg::CMD_LOW_SP : fms_pkg::CMD_STREAM_STOP;
          fms_pkg::MODE_LEVEL:
            ev.cmd = fms_pkg::CMD_LOW_SP;
          fms_pkg::MODE_AWAIT:
            ev.cmd = k == 0 ? fms_pkg::CMD_LAND : k == 1 ? fms_pkg::CMD_GOTO :
                     fms_pkg::CMD_START_TRAJ;
          fms_pkg::MODE_HI_LEVEL:
            ev.cmd = k == 0 ? fms_pkg::CMD_LOW_SP : k == 1 ? fms_pkg::CMD_LAND :
                     k == 2 ? fms_pkg::CMD_GOTO : k == 3 ? fms_pkg::CMD_START_TRAJ :
                     fms_pkg::CMD_FIN_QUERY;
          fms_pkg::MODE_LANDING:
            ev.cmd = fms_pkg::CMD_FIN_QUERY;
          default:
            ev.cmd = fms_pkg::CMD_ESTOP;
        endcase
      end else ev.cmd = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 4))
        0: ev.now_ms = $urandom;
        1: ev.now_ms = flight_state.last_low + lev_limit + $urandom_range(0, 2) - 1;
        2: ev.now_ms = flight_state.last_low + emg_limit + $urandom_range(0, 2) - 1;
        3: ev.now_ms = flight_state.last_low + flight_state.await_limit
                       + $urandom_range(0, 2) - 1;
        default: ev.now_ms = flight_state.last_low + $urandom_range(0, 40);
      endcase
      case ($urandom_range(0, 3))
        0: ev.setpoint_time = ev.now_ms;
        1: ev.setpoint_time = $urandom;
        2: ev.setpoint_time = 32'hFFFF_FFFF - $urandom_range(0, 3);
        default: ev.setpoint_time = $urandom_range(0, 3);
      endcase
      case ($urandom_range(0, 3))
        0: ev.await_ms = $urandom;
        1: ev.await_ms = $urandom_range(0, 50);
        2: ev.await_ms = 32'd0;
        default: ev.await_ms = 32'hFFFF_FFFF;
      endcase
      ev.planner_accepted = $urandom_range(0, 9) < 8;
      ev.plan_finished = 1'($urandom_range(0, 1));
      ev.eval_valid = $urandom_range(0, 9) < 9;
      void'(supervise(flight_state, ev, ns));
      tries++;
    end while (!allow_emerg && ns.mode == fms_pkg::MODE_EMERG && tries < 8);
    // emergency is terminal until reset: hold it off until the last segment
    if (!allow_emerg && ns.mode == fms_pkg::MODE_EMERG) ev.cmd = fms_pkg::CMD_FIN_QUERY;
    return ev;
  endfunction

  function automatic void add_row(logic [3:0] cmd, logic [31:0] now_ms, logic [31:0] sp,
                                  logic [31:0] aw, bit acc, bit done, bit ev_ok);
    script_row_t row;
    row.ev = '{cmd, now_ms, sp, aw, acc, done, ev_ok};
    row.pinned = 1'b0;
    row.want = '{fms_pkg::ST_OK, fms_pkg::MODE_IDLE, fms_pkg::SRC_NULL, 1'b0};
    script.push_back(row);
  endfunction

  function automatic void pin(fms_pkg::status_t st, fms_pkg::mode_t md,
                              fms_pkg::source_t src, logic fin);
    script[script.size()-1].pinned = 1'b1;
    script[script.size()-1].want = '{st, md, src, fin};
  endfunction

  task automatic send_word(input fms_pkg::in_word_t ev, input bit pinned,
                           input verdict_t want);
    verdict_t got;
    sup_state_t ns;
    if (!quiet && $urandom_range(0, 99) < 16) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 16);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= ev.cmd;
    in_ch.now_ms <= ev.now_ms;
    in_ch.setpoint_time <= ev.setpoint_time;
    in_ch.await_ms <= ev.await_ms;
    in_ch.planner_accepted <= ev.planner_accepted;
    in_ch.plan_finished <= ev.plan_finished;
    in_ch.eval_valid <= ev.eval_valid;
    do @(posedge clk); while (!in_ch.ready);
    got = supervise(flight_state, ev, ns);
    flight_state = ns;
    due_verdicts.push_back(pinned ? want : got);
  endtask

  task automatic write_reg(input fms_pkg::reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == fms_pkg::REG_LEVELING) lev_limit = value;
    else emg_limit = value;
  endtask

  task automatic settle();
    while (due_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    verdict_t want;
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (due_verdicts.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: status %0d mode %0d source %0d finished %0d",
                   $time, out_ch.status, out_ch.mode_now, out_ch.output_source,
                   out_ch.finished);
        end else begin
          want = due_verdicts.pop_front();
          if (out_ch.status !== want.status || out_ch.mode_now !== want.mode ||
              out_ch.output_source !== want.src || out_ch.finished !== want.fin) begin
            mismatches++;
            $display("%0t: expected status %0d mode %0d source %0d finished %0d", $time,
                     want.status, want.mode, want.src, want.fin);
            $display("%0t:   actual status %0d mode %0d source %0d finished %0d", $time,
                     out_ch.status, out_ch.mode_now, out_ch.output_source,
                     out_ch.finished);
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = STALL_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else out_ch.ready <= quiet || $urandom_range(0, 99) >= 16;
    end
  end

  initial begin
    verdict_t blank;
    int unsigned split;
    blank = '{fms_pkg::ST_OK, fms_pkg::MODE_IDLE, fms_pkg::SRC_NULL, 1'b0};
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= fms_pkg::CMD_TICK;
    in_ch.now_ms <= '0;
    in_ch.setpoint_time <= '0;
    in_ch.await_ms <= '0;
    in_ch.planner_accepted <= 1'b0;
    in_ch.plan_finished <= 1'b0;
    in_ch.eval_valid <= 1'b0;

    add_row(fms_pkg::CMD_TICK, 0, 0, 0, 0, 0, 1);
    pin(fms_pkg::ST_OK, fms_pkg::MODE_IDLE, fms_pkg::SRC_NULL, 0);
    add_row(CMD_UNUSED_HI, '1, '1, '1, 1, 1, 1);
    pin(fms_pkg::ST_PERM, fms_pkg::MODE_IDLE, fms_pkg::SRC_NULL, 0);
    add_row(fms_pkg::CMD_FIN_QUERY, 0, 0, 0, 1, 1, 1);
    pin(fms_pkg::ST_PERM, fms_pkg::MODE_IDLE, fms_pkg::SRC_NULL, 0);
    add_row(fms_pkg::CMD_STREAM_STOP, 0, 0, '1, 1, 0, 1);
    pin(fms_pkg::ST_PERM, fms_pkg::MODE_IDLE, fms_pkg::SRC_NULL, 0);
    add_row(fms_pkg::CMD_LAND, 0, 0, 0, 1, 0, 1);
    pin(fms_pkg::ST_PERM, fms_pkg::MODE_IDLE, fms_pkg::SRC_NULL, 0);
    add_row(fms_pkg::CMD_TAKEOFF, 0, 0, 0, 0, 0, 1);
    pin(fms_pkg::ST_REFUSED, fms_pkg::MODE_IDLE, fms_pkg::SRC_NULL, 0);
    add_row(fms_pkg::CMD_TAKEOFF, 0, 0, 0, 1, 0, 1);
    pin(fms_pkg::ST_OK, fms_pkg::MODE_HI_LEVEL, fms_pkg::SRC_NULL, 0);
    add_row(fms_pkg::CMD_FIN_QUERY, 0, 0, 0, 1, 1, 1);
    pin(fms_pkg::ST_OK, fms_pkg::MODE_HI_LEVEL, fms_pkg::SRC_NULL, 1);
    add_row(fms_pkg::CMD_TICK, 100, 0, 0, 1, 0, 1);
    add_row(fms_pkg::CMD_GOTO, 0, 0, 0, 1, 0, 1);
    add_row(fms_pkg::CMD_START_TRAJ, 0, 0, 0, 0, 0, 1);
    pin(fms_pkg::ST_REFUSED, fms_pkg::MODE_HI_LEVEL, fms_pkg::SRC_NULL, 0);
    add_row(fms_pkg::CMD_LOW_SP, 0, 32'hFFFF_FFFF, 0, 1, 0, 1);
    add_row(fms_pkg::CMD_TICK, 32'hFFFF_FFFF, 0, 0, 1, 0, 1);
    add_row(fms_pkg::CMD_STREAM_STOP, 0, 0, 0, 1, 0, 1);
    add_row(fms_pkg::CMD_TICK, 32'hFFFF_FFFF, 0, 0, 1, 0, 1);
    add_row(fms_pkg::CMD_LOW_SP, 7, 7, 0, 1, 0, 1);
    add_row(fms_pkg::CMD_LAND, 0, 0, 0, 0, 0, 1);
    add_row(fms_pkg::CMD_LAND, 0, 0, 0, 1, 0, 1);
    add_row(fms_pkg::CMD_TICK, 5, 0, 0, 1, 0, 1);
    add_row(fms_pkg::CMD_FIN_QUERY, 5, 0, 0, 1, 0, 1);
    add_row(fms_pkg::CMD_TICK, 6, 0, 0, 1, 1, 1);
    add_row(fms_pkg::CMD_LOW_SP, 0, 0, 0, 1, 0, 1);
    add_row(fms_pkg::CMD_TICK, 1, 0, 0, 1, 0, 1);
    add_row(CMD_UNUSED_LO, 1, 0, 0, 1, 0, 1);
    add_row(fms_pkg::CMD_LOW_SP, 5, 5, 0, 1, 0, 1);
    split = script.size();
    add_row(fms_pkg::CMD_ESTOP, 0, 0, 0, 0, 0, 0);
    pin(fms_pkg::ST_OK, fms_pkg::MODE_EMERG, fms_pkg::SRC_NULL, 0);
    add_row(fms_pkg::CMD_LOW_SP, 0, 0, 0, 1, 0, 1);
    pin(fms_pkg::ST_PERM, fms_pkg::MODE_EMERG, fms_pkg::SRC_NULL, 0);
    add_row(fms_pkg::CMD_TICK, 0, 0, 0, 1, 1, 0);
    pin(fms_pkg::ST_OK, fms_pkg::MODE_EMERG, fms_pkg::SRC_NULL, 0);
    add_row(fms_pkg::CMD_GOTO, 0, 0, 0, 1, 0, 1);
    pin(fms_pkg::ST_PERM, fms_pkg::MODE_EMERG, fms_pkg::SRC_NULL, 0);
    add_row(fms_pkg::CMD_ESTOP, '1, '1, '1, 1, 1, 1);
    pin(fms_pkg::ST_OK, fms_pkg::MODE_EMERG, fms_pkg::SRC_NULL, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < split; i++) send_word(script[i].ev, script[i].pinned, script[i].want);
    in_ch.valid <= 1'b0;
    settle();

    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        lev_plan[5] = $urandom_range(1, 60);
        emg_plan[5] = $urandom_range(1, 60);
      end
      write_reg(fms_pkg::REG_LEVELING, lev_plan[p]);
      write_reg(fms_pkg::REG_EMERGENCY, emg_plan[p]);
      quiet = (p == 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 2 && n == 40) begin
          quiet = 1'b1;
          hold_req = 1'b1;
        end
        if (p == 2 && n == 120) quiet = 1'b0;
        if (p == 3 && n == 95) begin
          in_ch.valid <= 1'b0;
          settle();
        end
        send_word(draw_event(1'b0), 1'b0, blank);
      end
      in_ch.valid <= 1'b0;
      settle();
    end

    // emergency allowed from here on; the closing rows run in that mode
    quiet = 1'b0;
    for (int n = 0; n < 100; n++) send_word(draw_event(1'b1), 1'b0, blank);
    for (int i = split; i < script.size(); i++)
      send_word(script[i].ev, script[i].pinned, script[i].want);
    in_ch.valid <= 1'b0;
    settle();
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
